/* hdl/ping_pong_flash_record_store_macros.svh */
// Assertion macros shared by the store's RTL files.
// They expect a clock named clk and an active-low reset named rst_n in scope.
`ifndef PING_PONG_FLASH_RECORD_STORE_MACROS_SVH
`define PING_PONG_FLASH_RECORD_STORE_MACROS_SVH

`ifndef SYNTHESIS
`define PPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PPS_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define PPS_ASSERT(lbl, prop, msg)
`define PPS_ASSERT_IMPLY(lbl, ante, cons, msg)
`endif

`endif

/* hdl/pps_pkg.sv */
package pps_pkg;

  // The sector size must be a power of two so that store addresses wrap by masking.
  localparam int unsigned SECTOR_BYTES = 32768;
  localparam int unsigned STORE_TOTAL  = 2 * SECTOR_BYTES;
  localparam int unsigned AW           = $clog2(STORE_TOTAL);

  localparam logic [2:0] OP_OPEN   = 3'd0;
  localparam logic [2:0] OP_APPEND = 3'd1;
  localparam logic [2:0] OP_COMMIT = 3'd2;
  localparam logic [2:0] OP_FIND   = 3'd3;
  localparam logic [2:0] OP_READ   = 3'd4;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_SAME  = 3'd1;
  localparam logic [2:0] ST_SWAP  = 3'd2;
  localparam logic [2:0] ST_FULL  = 3'd3;
  localparam logic [2:0] ST_RANGE = 3'd4;
  localparam logic [2:0] ST_NONE  = 3'd5;

  localparam logic [7:0] MARK_ERASED  = 8'hFF;
  localparam logic [7:0] MARK_PENDING = 8'h7F;
  localparam logic [7:0] MARK_LIVE    = 8'h3F;
  localparam logic [7:0] MARK_OLD     = 8'h1F;

  typedef struct packed {
    logic [2:0]  operation;
    logic [7:0]  data_byte;
    logic [14:0] read_offset;
  } pps_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  read_data;
    logic [15:0] record_base;
    logic [15:0] record_length;
    logic [15:0] write_position;
  } pps_out_t;

  typedef enum logic [1:0] {
    CMD_IDLE,
    CMD_READ,
    CMD_PROG,
    CMD_WRITE
  } pps_cmd_kind_t;

  typedef struct packed {
    pps_cmd_kind_t   kind;
    logic [AW-1:0]   addr;
    logic [7:0]      data;
  } pps_cmd_t;

  typedef struct packed {
    logic [7:0] rdata;
  } pps_stat_t;

endpackage

/* hdl/pps_ram.sv */
module pps_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/pps_dp.sv */
`include "ping_pong_flash_record_store_macros.svh"

module pps_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  pps_pkg::pps_cmd_t  cmd,
  output pps_pkg::pps_stat_t stat
);
  import pps_pkg::*;

  logic          prog_pend_r;
  logic [AW-1:0] prog_addr_r;
  logic [7:0]    prog_val_r;
  logic          we;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;
  logic [7:0]    rdata;

  // A program is a read-modify-write: the byte is read now and the AND is written next cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prog_pend_r <= 1'b0;
    end else begin
      prog_pend_r <= (cmd.kind == CMD_PROG);
    end
    prog_addr_r <= cmd.addr;
    prog_val_r  <= cmd.data;
  end

  always_comb begin
    if (prog_pend_r) begin
      we    = 1'b1;
      waddr = prog_addr_r;
      wdata = rdata & prog_val_r;
    end else begin
      we    = (cmd.kind == CMD_WRITE);
      waddr = cmd.addr;
      wdata = cmd.data;
    end
  end

  pps_ram #(
    .WIDTH(8),
    .DEPTH(STORE_TOTAL)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(cmd.addr),
    .rdata(rdata)
  );

  assign stat.rdata = rdata;

  `PPS_ASSERT_IMPLY(a_prog_no_write, prog_pend_r, cmd.kind != CMD_WRITE, "write collides with program")

endmodule

/* hdl/pps_ctrl.sv */
`include "ping_pong_flash_record_store_macros.svh"

module pps_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  pps_pkg::pps_in_t   in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output pps_pkg::pps_out_t  out_word,
  output pps_pkg::pps_cmd_t  cmd,
  input  pps_pkg::pps_stat_t stat
);
  import pps_pkg::*;

  localparam int unsigned PW = 18;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_RD, S_SCAN_B, S_SCAN_M, S_SCAN_H, S_SCAN_L,
    S_OPEN_EVAL, S_OPEN_P, S_ERASE, S_OPEN_PROG, S_CMT_HI, S_CMT_LO,
    S_CMT_GAP, S_CMT_LIVE, S_CMT_GAP2, S_CMT_OLD, S_FIN
  } state_t;

  state_t        state_r, state_nxt;
  logic [2:0]    op_r, op_nxt;
  logic [2:0]    st_r, st_nxt;
  logic [7:0]    rd_r, rd_nxt;
  logic [15:0]   pb_r, pb_nxt;
  logic [15:0]   ap_r, ap_nxt;
  logic          pend_r, pend_nxt;
  logic [15:0]   lb_r, lb_nxt;
  logic [15:0]   ll_r, ll_nxt;
  logic          lf_r, lf_nxt;
  logic          sec_r, sec_nxt;
  logic [AW-1:0] pos_r, pos_nxt;
  logic [7:0]    b_r, b_nxt;
  logic [7:0]    hi_r, hi_nxt;
  logic          sh_r, sh_nxt;
  logic [AW-1:0] sb_r, sb_nxt;
  logic [AW-1:0] start_r, start_nxt;
  logic [AW-1:0] er_addr_r, er_addr_nxt;
  logic [AW-1:0] er_last_r, er_last_nxt;
  logic          out_valid_r, out_valid_nxt;
  pps_out_t      out_r, out_nxt;

  logic          scan_done;
  logic          scan_hit;
  logic          adv_sec;
  logic [15:0]   l_cur;
  logic [PW-1:0] npos;
  logic [PW-1:0] sec_end;
  logic [PW-1:0] p_cur;
  logic [PW-1:0] p_end;
  logic [PW-1:0] ap_end;
  logic [15:0]   cmt_len;
  logic          swap;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  assign l_cur   = {hi_r, stat.rdata};
  assign npos    = PW'(pos_r) + PW'(l_cur);
  assign sec_end = sec_r ? PW'(STORE_TOTAL) : PW'(SECTOR_BYTES);
  assign p_cur   = PW'(lb_r) + PW'(ll_r);
  assign p_end   = (p_cur >= PW'(SECTOR_BYTES)) ? PW'(STORE_TOTAL) : PW'(SECTOR_BYTES);
  assign ap_end  = (PW'(pb_r) >= PW'(SECTOR_BYTES)) ? PW'(STORE_TOTAL) : PW'(SECTOR_BYTES);
  assign cmt_len = ap_r - pb_r;
  assign swap    = ((p_cur + PW'({ll_r, 1'b0})) >= p_end) || (stat.rdata != MARK_ERASED);

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    st_nxt        = st_r;
    rd_nxt        = rd_r;
    pb_nxt        = pb_r;
    ap_nxt        = ap_r;
    pend_nxt      = pend_r;
    lb_nxt        = lb_r;
    ll_nxt        = ll_r;
    lf_nxt        = lf_r;
    sec_nxt       = sec_r;
    pos_nxt       = pos_r;
    b_nxt         = b_r;
    hi_nxt        = hi_r;
    sh_nxt        = sh_r;
    sb_nxt        = sb_r;
    start_nxt     = start_r;
    er_addr_nxt   = er_addr_r;
    er_last_nxt   = er_last_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    cmd           = '{kind: CMD_IDLE, addr: '0, data: '0};
    scan_done     = 1'b0;
    scan_hit      = 1'b0;
    adv_sec       = 1'b0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR, S_ERASE: begin
        cmd = '{kind: CMD_WRITE, addr: er_addr_r, data: MARK_ERASED};
        er_addr_nxt = er_addr_r + 1'b1;
        if (er_addr_r == er_last_r) begin
          state_nxt = (state_r == S_CLEAR) ? S_IDLE : S_OPEN_PROG;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          op_nxt = in_word.operation;
          st_nxt = ST_OK;
          rd_nxt = '0;
          state_nxt = S_FIN;
          case (in_word.operation)
            OP_OPEN, OP_FIND: begin
              sec_nxt   = 1'b0;
              pos_nxt   = '0;
              state_nxt = S_SCAN_B;
            end
            OP_APPEND: begin
              if (pend_r && (ap_r >= pb_r) && (PW'(ap_r) < ap_end)) begin
                cmd = '{kind: CMD_PROG, addr: AW'(ap_r), data: in_word.data_byte};
                ap_nxt = ap_r + 16'd1;
              end else begin
                st_nxt = ST_FULL;
              end
            end
            OP_COMMIT: begin
              if (!pend_r) begin
                st_nxt = ST_NONE;
              end else begin
                state_nxt = S_CMT_HI;
              end
            end
            OP_READ: begin
              if (!lf_r) begin
                st_nxt = ST_NONE;
              end else if ((17'(in_word.read_offset) + 17'd3) >= 17'(ll_r)) begin
                st_nxt = ST_RANGE;
              end else begin
                cmd = '{kind: CMD_READ,
                        addr: AW'(PW'(lb_r) + PW'(3) + PW'(in_word.read_offset)),
                        data: '0};
                state_nxt = S_RD;
              end
            end
            default: begin
              st_nxt = ST_OK;
            end
          endcase
        end
      end
      S_RD: begin
        rd_nxt    = stat.rdata;
        state_nxt = S_FIN;
      end
      S_SCAN_B: begin
        cmd = '{kind: CMD_READ, addr: pos_r, data: '0};
        state_nxt = S_SCAN_M;
      end
      S_SCAN_M: begin
        b_nxt = stat.rdata;
        if (stat.rdata == MARK_ERASED) begin
          adv_sec = 1'b1;
        end else begin
          cmd = '{kind: CMD_READ, addr: pos_r + AW'(1), data: '0};
          state_nxt = S_SCAN_H;
        end
      end
      S_SCAN_H: begin
        hi_nxt = stat.rdata;
        cmd = '{kind: CMD_READ, addr: pos_r + AW'(2), data: '0};
        state_nxt = S_SCAN_L;
      end
      S_SCAN_L: begin
        if (b_r == MARK_LIVE) begin
          scan_done = 1'b1;
          scan_hit  = 1'b1;
        end else if (l_cur == 16'd0 || npos >= sec_end) begin
          adv_sec = 1'b1;
        end else begin
          pos_nxt   = AW'(npos);
          state_nxt = S_SCAN_B;
        end
      end
      S_OPEN_EVAL: begin
        st_nxt = ST_SWAP;
        if (!lf_r) begin
          er_addr_nxt = '0;
          er_last_nxt = AW'(STORE_TOTAL - 1);
          start_nxt   = AW'(SECTOR_BYTES);
          state_nxt   = S_ERASE;
        end else if (p_cur >= PW'(STORE_TOTAL)) begin
          er_addr_nxt = '0;
          er_last_nxt = AW'(SECTOR_BYTES - 1);
          start_nxt   = '0;
          state_nxt   = S_ERASE;
        end else begin
          cmd = '{kind: CMD_READ, addr: AW'(p_cur), data: '0};
          state_nxt = S_OPEN_P;
        end
      end
      S_OPEN_P: begin
        if (swap) begin
          st_nxt    = ST_SWAP;
          state_nxt = S_ERASE;
          if (p_cur >= PW'(SECTOR_BYTES)) begin
            er_addr_nxt = '0;
            er_last_nxt = AW'(SECTOR_BYTES - 1);
            start_nxt   = '0;
          end else begin
            er_addr_nxt = AW'(SECTOR_BYTES);
            er_last_nxt = AW'(STORE_TOTAL - 1);
            start_nxt   = AW'(SECTOR_BYTES);
          end
        end else begin
          st_nxt    = ST_SAME;
          start_nxt = AW'(p_cur);
          state_nxt = S_OPEN_PROG;
        end
      end
      S_OPEN_PROG: begin
        cmd = '{kind: CMD_PROG, addr: start_r, data: MARK_PENDING};
        pb_nxt    = 16'(start_r);
        ap_nxt    = 16'(start_r) + 16'd3;
        pend_nxt  = 1'b1;
        state_nxt = S_FIN;
      end
      S_CMT_HI: begin
        cmd = '{kind: CMD_PROG, addr: AW'(pb_r + 16'd1), data: cmt_len[15:8]};
        state_nxt = S_CMT_LO;
      end
      S_CMT_LO: begin
        cmd = '{kind: CMD_PROG, addr: AW'(pb_r + 16'd2), data: cmt_len[7:0]};
        state_nxt = S_CMT_GAP;
      end
      S_CMT_GAP: begin
        sec_nxt   = 1'b0;
        pos_nxt   = '0;
        state_nxt = S_SCAN_B;
      end
      S_CMT_LIVE: begin
        cmd = '{kind: CMD_PROG, addr: AW'(pb_r), data: MARK_LIVE};
        lb_nxt    = pb_r;
        ll_nxt    = cmt_len;
        lf_nxt    = 1'b1;
        pend_nxt  = 1'b0;
        state_nxt = S_CMT_GAP2;
      end
      S_CMT_GAP2: begin
        state_nxt = sh_r ? S_CMT_OLD : S_FIN;
      end
      S_CMT_OLD: begin
        cmd = '{kind: CMD_PROG, addr: sb_r, data: MARK_OLD};
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '0;
          out_nxt.status = st_r;
          case (op_r)
            OP_OPEN: begin
              out_nxt.record_base    = pb_r;
              out_nxt.record_length  = ll_r;
              out_nxt.write_position = ap_r;
            end
            OP_APPEND: begin
              out_nxt.record_base    = pb_r;
              out_nxt.write_position = ap_r;
            end
            OP_COMMIT: begin
              out_nxt.record_base    = pb_r;
              out_nxt.record_length  = (st_r == ST_NONE) ? 16'd0 : ll_r;
              out_nxt.write_position = ap_r;
            end
            OP_FIND, OP_READ: begin
              out_nxt.read_data     = rd_r;
              out_nxt.record_base   = lb_r;
              out_nxt.record_length = ll_r;
            end
            default: begin
              out_nxt.status = ST_OK;
            end
          endcase
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Leaving sector 0 restarts the walk at sector 1; leaving sector 1 ends it empty-handed.
    if (adv_sec) begin
      if (!sec_r) begin
        sec_nxt   = 1'b1;
        pos_nxt   = AW'(SECTOR_BYTES);
        state_nxt = S_SCAN_B;
      end else begin
        scan_done = 1'b1;
      end
    end

    if (scan_done) begin
      sh_nxt = scan_hit;
      sb_nxt = pos_r;
      case (op_r)
        OP_COMMIT: begin
          state_nxt = S_CMT_LIVE;
        end
        OP_OPEN: begin
          lf_nxt    = scan_hit;
          lb_nxt    = scan_hit ? 16'(pos_r) : 16'd0;
          ll_nxt    = scan_hit ? l_cur : 16'd0;
          state_nxt = S_OPEN_EVAL;
        end
        default: begin
          lf_nxt    = scan_hit;
          lb_nxt    = scan_hit ? 16'(pos_r) : 16'd0;
          ll_nxt    = scan_hit ? l_cur : 16'd0;
          st_nxt    = scan_hit ? ST_OK : ST_NONE;
          state_nxt = S_FIN;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      op_r        <= OP_OPEN;
      st_r        <= ST_OK;
      rd_r        <= '0;
      pb_r        <= '0;
      ap_r        <= '0;
      pend_r      <= 1'b0;
      lb_r        <= '0;
      ll_r        <= '0;
      lf_r        <= 1'b0;
      sec_r       <= 1'b0;
      pos_r       <= '0;
      sh_r        <= 1'b0;
      er_addr_r   <= '0;
      er_last_r   <= AW'(STORE_TOTAL - 1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      st_r        <= st_nxt;
      rd_r        <= rd_nxt;
      pb_r        <= pb_nxt;
      ap_r        <= ap_nxt;
      pend_r      <= pend_nxt;
      lb_r        <= lb_nxt;
      ll_r        <= ll_nxt;
      lf_r        <= lf_nxt;
      sec_r       <= sec_nxt;
      pos_r       <= pos_nxt;
      sh_r        <= sh_nxt;
      er_addr_r   <= er_addr_nxt;
      er_last_r   <= er_last_nxt;
      out_valid_r <= out_valid_nxt;
    end
    b_r     <= b_nxt;
    hi_r    <= hi_nxt;
    sb_r    <= sb_nxt;
    start_r <= start_nxt;
    out_r   <= out_nxt;
  end

  `PPS_ASSERT_IMPLY(a_erase_bound, state_r == S_ERASE || state_r == S_CLEAR, er_addr_r <= er_last_r, "erase sweep overran its range")
  `PPS_ASSERT(a_fin_waits, (state_r == S_FIN && out_valid_r && out_stall) |=> (state_r == S_FIN), "result finished over a stalled word")

endmodule

/* hdl/ping_pong_flash_record_store.sv */
// Append programs one byte with a single RAM read-modify-write; a read fetches one RAM byte.
// Find walks the record headers, reading each header's bytes one at a time from the RAM's
// single read port. An open that starts in the other sector adds an erase sweep of one byte
// per cycle: SECTOR_BYTES, or 2*SECTOR_BYTES when nothing is live. Commit programs the length
// bytes, walks the headers and marks the new record live and any old one old. One item is in
// flight at a time. After reset all 65536 bytes are cleared to 0xFF with in_stall high.
module ping_pong_flash_record_store (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  pps_pkg::pps_in_t  in_word,
  output logic              out_valid,
  input  logic              out_stall,
  output pps_pkg::pps_out_t out_word
);
  import pps_pkg::*;

  pps_cmd_t  cmd;
  pps_stat_t stat;

  pps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word),
    .cmd      (cmd),
    .stat     (stat)
  );

  pps_dp u_dp (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (cmd),
    .stat (stat)
  );

endmodule

/* verif/ping_pong_flash_record_store_tb.sv */
`timescale 1ns / 1ps

module ping_pong_flash_record_store_tb;
  import pps_pkg::*;

  localparam int ITEMS = 1950;
  localparam int MAX_OPENS = 18;
  localparam int IDLE_LIMIT = 300000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  pps_in_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  pps_out_t out_word;

  ping_pong_flash_record_store DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow copy of the flash array and the record pointers.
  logic [7:0] flash_img [0:STORE_TOTAL-1];
  logic [15:0] pend_base, app_ptr, live_base_m, live_len;
  bit pend_open, live_ok;

  pps_out_t result_q[$];
  int mismatches = 0;
  int accepted = 0;
  int opens_sent = 0;
  int idle_cycles = 0;
  bit quiet = 1'b0;

  function automatic logic [7:0] flash_rd(int unsigned a);
    return flash_img[a % STORE_TOTAL];
  endfunction

  function automatic void flash_prog(int unsigned a, logic [7:0] v);
    flash_img[a % STORE_TOTAL] &= v;
  endfunction

  function automatic void erase_sector(int unsigned sec);
    for (int unsigned i = 0; i < SECTOR_BYTES; i++)
      flash_img[(sec & 1) * SECTOR_BYTES + i] = MARK_ERASED;
  endfunction

  function automatic bit scan_for_live(output logic [15:0] base, output logic [15:0] len);
    int unsigned pos, lim, l;
    logic [7:0] b;
    base = '0;
    len = '0;
    for (int unsigned sec = 0; sec < 2; sec++) begin
      pos = sec * SECTOR_BYTES;
      lim = pos + SECTOR_BYTES;
      b = flash_rd(pos);
      while (b != MARK_ERASED) begin
        l = {flash_rd(pos + 1), flash_rd(pos + 2)};
        if (b == MARK_LIVE) begin
          base = pos[15:0];
          len = l[15:0];
          return 1'b1;
        end
        if (l == 0) break;
        pos += l;
        if (pos >= lim) break;
        b = flash_rd(pos);
      end
    end
    return 1'b0;
  endfunction

  function automatic void locate_live();
    logic [15:0] b, l;
    live_ok = scan_for_live(b, l);
    live_base_m = live_ok ? b : '0;
    live_len = live_ok ? l : '0;
  endfunction

  function automatic pps_out_t store_step(pps_in_t w);
    pps_out_t r;
    int unsigned start, p, sec, lim;
    logic [15:0] len, ob, ol;
    bit swap, had;
    r = '0;
    case (w.operation)
      OP_OPEN: begin
        locate_live();
        if (!live_ok) begin
          erase_sector(0);
          erase_sector(1);
          start = SECTOR_BYTES;
          r.status = ST_SWAP;
        end else begin
          p = live_base_m + live_len;
          sec = p / SECTOR_BYTES;
          if (p >= STORE_TOTAL) swap = 1'b1;
          else swap = (p + 2 * live_len >= (sec + 1) * SECTOR_BYTES) ||
                      flash_rd(p) != MARK_ERASED;
          if (swap) begin
            if (sec != 0) begin
              start = 0;
              erase_sector(0);
            end else begin
              start = SECTOR_BYTES;
              erase_sector(1);
            end
            r.status = ST_SWAP;
          end else begin
            start = p;
            r.status = ST_SAME;
          end
        end
        pend_base = start[15:0];
        flash_prog(start, MARK_PENDING);
        app_ptr = start[15:0] + 16'd3;
        pend_open = 1'b1;
        r.record_base = pend_base;
        r.record_length = live_len;
        r.write_position = app_ptr;
      end
      OP_APPEND: begin
        lim = (pend_base / SECTOR_BYTES + 1) * SECTOR_BYTES;
        if (pend_open && app_ptr >= pend_base && app_ptr < lim) begin
          flash_prog(app_ptr, w.data_byte);
          app_ptr = app_ptr + 16'd1;
        end else begin
          r.status = ST_FULL;
        end
        r.record_base = pend_base;
        r.write_position = app_ptr;
      end
      OP_COMMIT: begin
        if (!pend_open) begin
          r.status = ST_NONE;
        end else begin
          len = app_ptr - pend_base;
          flash_prog(pend_base + 1, len[15:8]);
          flash_prog(pend_base + 2, len[7:0]);
          had = scan_for_live(ob, ol);
          flash_prog(pend_base, MARK_LIVE);
          if (had) flash_prog(ob, MARK_OLD);
          live_base_m = pend_base;
          live_len = len;
          live_ok = 1'b1;
          pend_open = 1'b0;
          r.record_length = len;
        end
        r.record_base = pend_base;
        r.write_position = app_ptr;
      end
      OP_FIND: begin
        locate_live();
        r.status = live_ok ? ST_OK : ST_NONE;
        r.record_base = live_base_m;
        r.record_length = live_len;
      end
      OP_READ: begin
        if (!live_ok) begin
          r.status = ST_NONE;
        end else begin
          r.record_base = live_base_m;
          r.record_length = live_len;
          if (w.read_offset + 3 >= live_len) r.status = ST_RANGE;
          else r.read_data = flash_rd(live_base_m + 3 + w.read_offset);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // The checked expectation is the predictor's unless a row types one in.
  task automatic send_word(pps_in_t w, bit typed, pps_out_t e);
    pps_out_t pred;
    in_word <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = store_step(w);
    result_q.push_back(typed ? e : pred);
    accepted++;
    if (w.operation == OP_OPEN) opens_sent++;
    @(negedge clk);
  endtask

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic idle_gap();
    int g;
    g = pick_gap();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
  endtask

  task automatic send_op(logic [2:0] op, logic [7:0] d, logic [14:0] offs);
    pps_in_t w;
    w.operation = op;
    w.data_byte = d;
    w.read_offset = offs;
    send_word(w, 1'b0, '0);
    idle_gap();
    if (accepted % 150 == 0) quiet = ($urandom_range(0, 3) == 0);
  endtask

  // Receiver back-pressure, with quiet stretches.
  int stall_left = 0;
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 99) < 30) begin
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    pps_out_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (result_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: %p", out_word);
      end else begin
        e = result_q.pop_front();
        if (out_word.status !== e.status || out_word.read_data !== e.read_data ||
            out_word.record_base !== e.record_base ||
            out_word.record_length !== e.record_length ||
            out_word.write_position !== e.write_position) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", e, out_word);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  typedef struct {
    pps_in_t w;
    bit typed;
    pps_out_t e;
  } stim_row_t;

  function automatic stim_row_t mk_row(logic [2:0] op, logic [7:0] d, logic [14:0] offs,
                                       bit typed, logic [2:0] st, logic [15:0] base,
                                       logic [15:0] wpos);
    stim_row_t r;
    r.w.operation = op;
    r.w.data_byte = d;
    r.w.read_offset = offs;
    r.typed = typed;
    r.e = '0;
    r.e.status = st;
    r.e.record_base = base;
    r.e.write_position = wpos;
    return r;
  endfunction

  stim_row_t directed[$];

  initial begin
    int n;
    for (int i = 0; i < STORE_TOTAL; i++) flash_img[i] = MARK_ERASED;
    pend_base = '0; app_ptr = '0; live_base_m = '0; live_len = '0;
    pend_open = 1'b0; live_ok = 1'b0;

    // Empty store and undefined opcodes first, then a first record, range checks and a continued one.
    directed.push_back(mk_row(OP_FIND, 8'h00, 15'd0, 1, ST_NONE, 16'h0, 16'h0));
    directed.push_back(mk_row(OP_READ, 8'h00, 15'd0, 1, ST_NONE, 16'h0, 16'h0));
    directed.push_back(mk_row(OP_COMMIT, 8'h00, 15'd0, 1, ST_NONE, 16'h0, 16'h0));
    directed.push_back(mk_row(OP_APPEND, 8'hA5, 15'd0, 1, ST_FULL, 16'h0, 16'h0));
    directed.push_back(mk_row(3'd7, 8'hFF, 15'h7FFF, 1, ST_OK, 16'h0, 16'h0));
    directed.push_back(mk_row(3'd5, 8'h00, 15'd0, 1, ST_OK, 16'h0, 16'h0));
    directed.push_back(mk_row(3'd6, 8'h55, 15'h2AAA, 1, ST_OK, 16'h0, 16'h0));
    directed.push_back(mk_row(OP_OPEN, 8'h00, 15'd0, 1, ST_SWAP, 16'h8000, 16'h8003));
    directed.push_back(mk_row(OP_APPEND, 8'h00, 15'd0, 1, ST_OK, 16'h8000, 16'h8004));
    directed.push_back(mk_row(OP_APPEND, 8'hFF, 15'd0, 1, ST_OK, 16'h8000, 16'h8005));
    directed.push_back(mk_row(OP_APPEND, 8'h5A, 15'd0, 0, ST_OK, 16'h0, 16'h0));
    directed.push_back(mk_row(OP_COMMIT, 8'h00, 15'd0, 0, ST_OK, 16'h0, 16'h0));
    directed.push_back(mk_row(OP_FIND, 8'h00, 15'd0, 0, ST_OK, 16'h0, 16'h0));
    directed.push_back(mk_row(OP_READ, 8'h00, 15'd0, 0, ST_OK, 16'h0, 16'h0));
    directed.push_back(mk_row(OP_READ, 8'h00, 15'd2, 0, ST_OK, 16'h0, 16'h0));
    directed.push_back(mk_row(OP_READ, 8'h00, 15'd3, 0, ST_OK, 16'h0, 16'h0));
    directed.push_back(mk_row(OP_READ, 8'h00, 15'h7FFF, 0, ST_OK, 16'h0, 16'h0));
    directed.push_back(mk_row(OP_OPEN, 8'h00, 15'd0, 0, ST_OK, 16'h0, 16'h0));
    directed.push_back(mk_row(OP_COMMIT, 8'h00, 15'd0, 0, ST_OK, 16'h0, 16'h0));
    directed.push_back(mk_row(OP_READ, 8'h00, 15'd0, 0, ST_OK, 16'h0, 16'h0));
    directed.push_back(mk_row(OP_OPEN, 8'h00, 15'd0, 0, ST_OK, 16'h0, 16'h0));
    directed.push_back(mk_row(OP_APPEND, 8'h81, 15'd0, 0, ST_OK, 16'h0, 16'h0));
    directed.push_back(mk_row(OP_COMMIT, 8'h00, 15'd0, 0, ST_OK, 16'h0, 16'h0));
    directed.push_back(mk_row(OP_READ, 8'h00, 15'd0, 0, ST_OK, 16'h0, 16'h0));

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) begin
      send_word(directed[i].w, directed[i].typed, directed[i].e);
      idle_gap();
    end

    while (accepted < ITEMS) begin
      if (accepted > ITEMS / 2 && accepted < ITEMS / 2 + 10) begin
        // Let the pipeline drain completely around the halfway point.
        in_valid <= 1'b0;
        wait (result_q.size() == 0);
        @(negedge clk);
      end
      if ($urandom_range(0, 99) < 80) begin
        if (opens_sent < MAX_OPENS && $urandom_range(0, 99) < 4)
          send_op(OP_OPEN, 8'($urandom), 15'($urandom));
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 12);
        repeat (n) send_op(OP_APPEND, 8'($urandom), 15'($urandom));
        if ($urandom_range(0, 9) != 0) send_op(OP_COMMIT, 8'($urandom), 15'($urandom));
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 4) == 0) send_op(OP_FIND, 8'($urandom), 15'($urandom));
          else if ($urandom_range(0, 5) == 0) send_op(OP_READ, 8'($urandom), 15'($urandom));
          else send_op(OP_READ, 8'($urandom),
                       15'((live_len > 3) ? $urandom_range(0, live_len)
                                          : $urandom_range(0, 3)));
        end
      end else begin
        send_op(3'($urandom_range(1, 7)), 8'($urandom), 15'($urandom));
      end
    end

    in_valid <= 1'b0;
    wait (result_q.size() == 0);
    repeat (100) @(posedge clk);
    if (mismatches == 0 && result_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
